// ----- hdl/twm_pkg.sv -----
// Shared types and codes for the two-wire master byte engine.
package twm_pkg;

	localparam int unsigned TickW = 10;
	localparam int unsigned ByteW = 8;
	localparam int unsigned BitCntW = 4;
	localparam logic [BitCntW-1:0] LastDataBits = 4'd8;

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	typedef enum logic [10:0] {
		PH_IDLE = 11'b000_0000_0001,
		PH_ST1  = 11'b000_0000_0010,
		PH_ST2  = 11'b000_0000_0100,
		PH_ST3  = 11'b000_0000_1000,
		PH_DRV  = 11'b000_0001_0000,
		PH_DCLK = 11'b000_0010_0000,
		PH_REL  = 11'b000_0100_0000,
		PH_RCLK = 11'b000_1000_0000,
		PH_SP1  = 11'b001_0000_0000,
		PH_SP2  = 11'b010_0000_0000,
		PH_SP3  = 11'b100_0000_0000
	} phase_t;

	typedef struct packed {
		logic read;
		logic stop;
		logic ack;
		logic seen;
	} op_flags_t;

	typedef struct packed {
		logic [1:0]       action;
		logic [ByteW-1:0] data_byte;
		logic             send_start;
		logic             send_stop;
		logic             send_ack;
		logic             sda_in;
	} item_t;

	typedef struct packed {
		logic             scl_out;
		logic             sda_out;
		logic             sda_release;
		logic             busy_res;
		logic             done_res;
		logic             ack_seen;
		logic [ByteW-1:0] rx_byte;
	} result_t;

	typedef struct packed {
		phase_t phase;
		logic   sda;
		logic   rel;
	} bit_entry_t;

	// Phase and data line setting on entering a bit slot. Slots 0..7 carry the
	// byte, slot 8 is the acknowledge bit, driven or sampled the other way round.
	function automatic bit_entry_t enter_bit(input logic [BitCntW-1:0] bit_cnt,
		input logic rd, input logic ack, input logic [ByteW-1:0] shift);
		bit_entry_t e;
		if (bit_cnt < LastDataBits) begin
			if (rd) begin
				e = '{phase: PH_REL, sda: 1'b1, rel: 1'b1};
			end else begin
				e = '{phase: PH_DRV, sda: shift[ByteW-1], rel: 1'b0};
			end
		end else begin
			if (rd) begin
				e = '{phase: PH_DRV, sda: ~ack, rel: 1'b0};
			end else begin
				e = '{phase: PH_REL, sda: 1'b1, rel: 1'b1};
			end
		end
		return e;
	endfunction

endpackage

// ----- hdl/twm_core.sv -----
// Byte sequencer: line phases, bit counter, shifter and tick counter.
module twm_core import twm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  item_t            item,
	input  logic [TickW-1:0] phase_ticks,
	output result_t          res
);

	phase_t             phase_q, n_phase;
	logic [BitCntW-1:0] bit_q, n_bit;
	logic [ByteW-1:0]   shift_q, n_shift;
	logic [TickW-1:0]   tick_q, n_tick;
	op_flags_t          flags_q, n_flags;
	logic               scl_q, sda_q, rel_q;
	logic               n_scl, n_sda, n_rel;
	logic               done;
	logic [TickW-1:0]   limit;
	logic [TickW-1:0]   tick_inc;
	bit_entry_t         ent;

	assign limit    = (phase_ticks == '0) ? TickW'(1) : phase_ticks;
	assign tick_inc = tick_q + TickW'(1);

	always_comb begin
		n_phase = phase_q;
		n_bit   = bit_q;
		n_shift = shift_q;
		n_tick  = tick_q;
		n_flags = flags_q;
		n_scl   = scl_q;
		n_sda   = sda_q;
		n_rel   = rel_q;
		done    = 1'b0;
		ent     = '{phase: PH_IDLE, sda: 1'b1, rel: 1'b0};
		unique case (item.action)
			ACT_WRITE, ACT_READ: begin
				if (phase_q == PH_IDLE) begin
					n_flags.read = (item.action == ACT_READ);
					n_flags.ack  = (item.action == ACT_READ) && item.send_ack;
					n_flags.stop = item.send_stop;
					n_flags.seen = 1'b0;
					n_shift = (item.action == ACT_READ) ? '0 : item.data_byte;
					n_tick  = '0;
					n_bit   = '0;
					if (item.send_start) begin
						n_scl   = 1'b1;
						n_sda   = 1'b1;
						n_rel   = 1'b0;
						n_phase = PH_ST1;
					end else begin
						ent = enter_bit('0, n_flags.read, n_flags.ack, n_shift);
						n_phase = ent.phase;
						n_sda   = ent.sda;
						n_rel   = ent.rel;
					end
				end
			end
			ACT_TICK: begin
				if (phase_q != PH_IDLE) begin
					if (tick_inc >= limit) begin
						n_tick = '0;
						unique case (phase_q)
							PH_ST1: begin
								n_sda   = 1'b0;
								n_rel   = 1'b0;
								n_phase = PH_ST2;
							end
							PH_ST2: begin
								n_scl   = 1'b0;
								n_phase = PH_ST3;
							end
							PH_ST3: begin
								n_bit   = '0;
								ent     = enter_bit('0, flags_q.read, flags_q.ack, shift_q);
								n_phase = ent.phase;
								n_sda   = ent.sda;
								n_rel   = ent.rel;
							end
							PH_DRV: begin
								n_scl   = 1'b1;
								n_phase = PH_DCLK;
							end
							PH_REL: begin
								n_scl   = 1'b1;
								n_phase = PH_RCLK;
							end
							PH_DCLK, PH_RCLK: begin
								n_scl = 1'b0;
								if (bit_q >= LastDataBits) begin
									if (phase_q == PH_RCLK) begin
										n_flags.seen = ~item.sda_in;
									end
									if (flags_q.stop) begin
										n_sda   = 1'b0;
										n_rel   = 1'b0;
										n_phase = PH_SP1;
									end else begin
										n_phase = PH_IDLE;
										done    = 1'b1;
									end
								end else begin
									n_shift = {shift_q[ByteW-2:0],
										(phase_q == PH_RCLK) & item.sda_in};
									n_bit   = bit_q + BitCntW'(1);
									ent     = enter_bit(n_bit, flags_q.read, flags_q.ack,
										n_shift);
									n_phase = ent.phase;
									n_sda   = ent.sda;
									n_rel   = ent.rel;
								end
							end
							PH_SP1: begin
								n_scl   = 1'b1;
								n_phase = PH_SP2;
							end
							PH_SP2: begin
								n_sda   = 1'b1;
								n_rel   = 1'b0;
								n_phase = PH_SP3;
							end
							PH_SP3: begin
								n_phase = PH_IDLE;
								done    = 1'b1;
							end
							default: begin
								n_phase = PH_IDLE;
							end
						endcase
					end else begin
						n_tick = tick_inc;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res.scl_out     = n_scl;
		res.sda_out     = n_sda | n_rel;
		res.sda_release = n_rel;
		res.busy_res    = (n_phase != PH_IDLE);
		res.done_res    = done;
		res.ack_seen    = done & ~n_flags.read & n_flags.seen;
		res.rx_byte     = (done && n_flags.read) ? n_shift : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bit_q   <= '0;
			shift_q <= '0;
			tick_q  <= '0;
			flags_q <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			rel_q   <= 1'b0;
		end else if (step) begin
			phase_q <= n_phase;
			bit_q   <= n_bit;
			shift_q <= n_shift;
			tick_q  <= n_tick;
			flags_q <= n_flags;
			scl_q   <= n_scl;
			sda_q   <= n_sda;
			rel_q   <= n_rel;
		end
	end

	// A finished byte always leaves the sequencer idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && done) |=> (phase_q == PH_IDLE))
		else $error("byte finished but sequencer not idle");

	// The bit counter never runs past the acknowledge slot.
	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= LastDataBits)
		else $error("bit counter out of range");

	// A released data line always reads back as high.
	a_rel_high: assert property (@(posedge clk) disable iff (!arst_n)
		rel_q |-> sda_q)
		else $error("data line released but level low");

	// Idle ticks change nothing on the lines.
	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_q == PH_IDLE && item.action == ACT_TICK)
		|=> ($stable(scl_q) && $stable(sda_q) && $stable(rel_q)))
		else $error("tick while idle moved a line");

endmodule

// ----- hdl/two_wire_master_byte_engine.sv -----
// Top level of the two-wire master byte engine: channels, input and result stages.
//
//  Channel   Handshake                 Payload
//  -------   ----------------------    ----------------------------------------------
//  input     in_valid / in_ready       action, data_byte, send_start, send_stop,
//                                      send_ack, sda_in
//  result    out_valid / out_ready     scl_out, sda_out, sda_release, busy_res,
//                                      done_res, ack_seen, rx_byte
//  config    cfg_valid / cfg_ready     cfg_data (phase length in ticks)
//
// Each request passes through the input stage and the result stage, and its result is
// offered from the result stage. One request is taken every cycle while the
// result side keeps up; the sequencer state is updated as a request leaves the input
// stage, so the next one sees it at once. Reset clears the sequencer to idle with
// both lines high and the phase length at one tick. A result side stall holds the
// result stage, and the input stage takes one more request before it stalls too.
module two_wire_master_byte_engine import twm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       action,
	input  logic [ByteW-1:0] data_byte,
	input  logic             send_start,
	input  logic             send_stop,
	input  logic             send_ack,
	input  logic             sda_in,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             scl_out,
	output logic             sda_out,
	output logic             sda_release,
	output logic             busy_res,
	output logic             done_res,
	output logic             ack_seen,
	output logic [ByteW-1:0] rx_byte,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [TickW-1:0] cfg_data
);

	logic             valid_s1;
	item_t            item_s1;
	logic             valid_s2;
	result_t          res_s2;
	result_t          res;
	logic [TickW-1:0] phase_ticks_q;
	logic             advance;

	// The result stage moves on when it is empty or being taken this cycle.
	assign advance   = !valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// The phase length register is always ready; the user is to write it only while no
	// request is in flight, which the block itself does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= TickW'(1);
		end else if (cfg_valid) begin
			phase_ticks_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{action: action, data_byte: data_byte, send_start: send_start,
				send_stop: send_stop, send_ack: send_ack, sda_in: sda_in};
		end
		if (advance && valid_s1) begin
			res_s2 <= res;
		end
	end

	// The sequencer steps exactly once per request, as it moves into the
	// result stage.
	twm_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance && valid_s1),
		.item        (item_s1),
		.phase_ticks (phase_ticks_q),
		.res         (res)
	);

	assign out_valid   = valid_s2;
	assign scl_out     = res_s2.scl_out;
	assign sda_out     = res_s2.sda_out;
	assign sda_release = res_s2.sda_release;
	assign busy_res    = res_s2.busy_res;
	assign done_res    = res_s2.done_res;
	assign ack_seen    = res_s2.ack_seen;
	assign rx_byte     = res_s2.rx_byte;

endmodule

// ----- bench/tb_two_wire_master_byte_engine.sv -----
// Self-checking testbench for the two-wire master byte engine with a line-level predictor.
`timescale 1ns / 1ps

module tb_two_wire_master_byte_engine;
	import twm_pkg::*;

	// The action field is two bits wide; the fourth code is no operation and
	// must leave the engine untouched.
	localparam logic [1:0] ACT_SPARE = 2'd3;

	// Predicts the clock and data line levels that the engine reports for
	// every request, and holds those predictions until the results arrive.
	class line_level_tracker;
		phase_t          phase;
		logic [BitCntW-1:0] bit_cnt;
		logic [ByteW-1:0] shifter;
		logic [TickW-1:0] tick_cnt;
		logic [TickW-1:0] phase_len;
		op_flags_t       flags;
		logic            scl;
		logic            sda;
		logic            rel;
		result_t         expected_lines[$];
		int unsigned     fail_count;

		function new();
			phase = PH_IDLE;
			bit_cnt = '0;
			shifter = '0;
			tick_cnt = '0;
			phase_len = 10'd1;
			flags = '0;
			scl = 1'b1;
			sda = 1'b1;
			rel = 1'b0;
			fail_count = 0;
		endfunction

		function bit busy();
			return phase != PH_IDLE;
		endfunction

		function int unsigned pending();
			return expected_lines.size();
		endfunction

		// Sets up the data line for the bit slot in bit_cnt. The ninth slot is
		// the acknowledge, which runs in the opposite direction to the byte.
		function void start_bit();
			if (bit_cnt < LastDataBits) begin
				if (flags.read) begin
					rel = 1'b1;
					sda = 1'b1;
					phase = PH_REL;
				end else begin
					rel = 1'b0;
					sda = shifter[ByteW-1];
					phase = PH_DRV;
				end
			end else if (flags.read) begin
				rel = 1'b0;
				sda = ~flags.ack;
				phase = PH_DRV;
			end else begin
				rel = 1'b1;
				sda = 1'b1;
				phase = PH_REL;
			end
		endfunction

		// Returns 1 when the byte ends here, 0 when a stop condition follows.
		function bit end_byte();
			if (flags.stop) begin
				rel = 1'b0;
				sda = 1'b0;
				phase = PH_SP1;
				return 1'b0;
			end
			phase = PH_IDLE;
			return 1'b1;
		endfunction

		function void take_request(item_t req);
			bit               finished;
			logic [TickW-1:0] limit;
			result_t          lines;
			finished = 1'b0;
			if (req.action == ACT_WRITE || req.action == ACT_READ) begin
				if (phase == PH_IDLE) begin
					flags = '0;
					flags.read = (req.action == ACT_READ);
					flags.ack = flags.read & req.send_ack;
					flags.stop = req.send_stop;
					shifter = flags.read ? '0 : req.data_byte;
					tick_cnt = '0;
					bit_cnt = '0;
					if (req.send_start) begin
						scl = 1'b1;
						sda = 1'b1;
						rel = 1'b0;
						phase = PH_ST1;
					end else begin
						start_bit();
					end
				end
			end else if (req.action == ACT_TICK && phase != PH_IDLE) begin
				limit = (phase_len == '0) ? 10'd1 : phase_len;
				tick_cnt = tick_cnt + 1'b1;
				if (tick_cnt >= limit) begin
					tick_cnt = '0;
					case (phase)
						PH_ST1: begin
							rel = 1'b0;
							sda = 1'b0;
							phase = PH_ST2;
						end
						PH_ST2: begin
							scl = 1'b0;
							phase = PH_ST3;
						end
						PH_ST3: begin
							bit_cnt = '0;
							start_bit();
						end
						PH_DRV: begin
							scl = 1'b1;
							phase = PH_DCLK;
						end
						PH_DCLK: begin
							scl = 1'b0;
							if (bit_cnt >= LastDataBits) begin
								finished = end_byte();
							end else begin
								shifter = shifter << 1;
								bit_cnt = bit_cnt + 1'b1;
								start_bit();
							end
						end
						PH_REL: begin
							scl = 1'b1;
							phase = PH_RCLK;
						end
						PH_RCLK: begin
							scl = 1'b0;
							if (bit_cnt >= LastDataBits) begin
								flags.seen = ~req.sda_in;
								finished = end_byte();
							end else begin
								shifter = {shifter[ByteW-2:0], req.sda_in};
								bit_cnt = bit_cnt + 1'b1;
								start_bit();
							end
						end
						PH_SP1: begin
							scl = 1'b1;
							phase = PH_SP2;
						end
						PH_SP2: begin
							rel = 1'b0;
							sda = 1'b1;
							phase = PH_SP3;
						end
						PH_SP3: begin
							phase = PH_IDLE;
							finished = 1'b1;
						end
						default: begin
							phase = PH_IDLE;
						end
					endcase
				end
			end
			lines.scl_out = scl;
			lines.sda_out = sda | rel;
			lines.sda_release = rel;
			lines.busy_res = (phase != PH_IDLE);
			lines.done_res = finished;
			lines.ack_seen = finished & ~flags.read & flags.seen;
			lines.rx_byte = (finished && flags.read) ? shifter : '0;
			expected_lines.push_back(lines);
		endfunction

		function void compare_field(string name, logic [ByteW-1:0] want, logic [ByteW-1:0] got);
			if (got !== want) begin
				$display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
				fail_count++;
			end
		endfunction

		function void check_lines(result_t got);
			result_t want;
			if (expected_lines.size() == 0) begin
				$display("%0t ns: result with none expected, expected nothing, got %p",
					$time, got);
				fail_count++;
				return;
			end
			want = expected_lines.pop_front();
			compare_field("scl_out", ByteW'(want.scl_out), ByteW'(got.scl_out));
			compare_field("sda_out", ByteW'(want.sda_out), ByteW'(got.sda_out));
			compare_field("sda_release", ByteW'(want.sda_release), ByteW'(got.sda_release));
			compare_field("busy_res", ByteW'(want.busy_res), ByteW'(got.busy_res));
			compare_field("done_res", ByteW'(want.done_res), ByteW'(got.done_res));
			compare_field("ack_seen", ByteW'(want.ack_seen), ByteW'(got.ack_seen));
			compare_field("rx_byte", want.rx_byte, got.rx_byte);
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [1:0]       action;
	logic [ByteW-1:0] data_byte;
	logic             send_start;
	logic             send_stop;
	logic             send_ack;
	logic             sda_in;
	logic             out_valid;
	logic             out_ready;
	logic             scl_out;
	logic             sda_out;
	logic             sda_release;
	logic             busy_res;
	logic             done_res;
	logic             ack_seen;
	logic [ByteW-1:0] rx_byte;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [TickW-1:0] cfg_data;

	line_level_tracker board;

	// When calm is set, neither side inserts gaps, so the engine is also
	// exercised at one request per cycle.
	bit calm;

	two_wire_master_byte_engine dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.data_byte   (data_byte),
		.send_start  (send_start),
		.send_stop   (send_stop),
		.send_ack    (send_ack),
		.sda_in      (sda_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.scl_out     (scl_out),
		.sda_out     (sda_out),
		.sda_release (sda_release),
		.busy_res    (busy_res),
		.done_res    (done_res),
		.ack_seen    (ack_seen),
		.rx_byte     (rx_byte),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always #1 clk = ~clk;

	// Both channels are observed at the rising edge. Every accepted request
	// feeds the predictor, and every accepted result is checked against the
	// oldest prediction. A result always comes after its request has been
	// accepted, so the prediction is in place before it is needed.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				board.take_request({action, data_byte, send_start, send_stop, send_ack,
					sda_in});
			end
			if (out_valid && out_ready) begin
				board.check_lines({scl_out, sda_out, sda_release, busy_res, done_res,
					ack_seen, rx_byte});
			end
		end
	end

	// Result side: before each result a random stall is drawn, none while calm is set,
	// and ready then stays high until that result has been taken.
	initial begin
		int unsigned stall;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			stall = calm ? 0 : $urandom_range(0, 7);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!(out_valid && out_ready)) @(posedge clk);
		end
	end

	// Offers one request after a random gap and holds it until it is taken.
	// The task is entered and left at a falling edge; valid is left high so
	// that back-to-back requests need no extra assignment.
	task automatic send_request(input item_t req);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		{action, data_byte, send_start, send_stop, send_ack, sda_in} <= req;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic item_t make_request(input logic [1:0] act, input logic [ByteW-1:0] byte_val,
		input logic start, input logic stop, input logic ack_bit, input logic level);
		item_t req;
		req.action = act;
		req.data_byte = byte_val;
		req.send_start = start;
		req.send_stop = stop;
		req.send_ack = ack_bit;
		req.sda_in = level;
		return req;
	endfunction

	// Ticks the engine through the rest of the current byte. The data line
	// level is the one the slave would present for the whole operation.
	task automatic tick_until_idle(input logic level);
		while (board.busy()) begin
			send_request(make_request(ACT_TICK, ByteW'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), level));
		end
	endtask

	// Waits until every prediction has been met, then lets the two-stage
	// pipeline run dry before anything is reconfigured or the run ends.
	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_phase_len(input logic [TickW-1:0] len);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= len;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.phase_len = len;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly well-formed traffic: a command while the engine is idle, then
	// ticks with a random data line until it finishes. The rest is noise:
	// ticks while idle, commands that arrive while busy, and the spare code.
	// Only requests that move the engine count towards the total; the phase
	// closes with the engine idle so that the next setting starts cleanly.
	task automatic drive_random(input int unsigned count);
		int unsigned useful;
		int unsigned steps;
		int unsigned pick;
		bit          engaged;
		item_t       req;
		useful = 0;
		steps = 0;
		while (useful < count) begin
			if (steps % 50 == 0) begin
				calm = ($urandom_range(0, 3) == 0);
			end
			steps++;
			engaged = board.busy();
			req = make_request(ACT_TICK, ByteW'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			pick = $urandom_range(0, 99);
			if (!engaged) begin
				if (pick < 85) begin
					req.action = $urandom_range(0, 1) ? ACT_WRITE : ACT_READ;
					useful++;
				end else if (pick >= 95) begin
					req.action = ACT_SPARE;
				end
			end else begin
				if (pick < 88) begin
					useful++;
				end else if (pick < 96) begin
					req.action = $urandom_range(0, 1) ? ACT_WRITE : ACT_READ;
				end else begin
					req.action = ACT_SPARE;
				end
			end
			send_request(req);
		end
		tick_until_idle(1'($urandom_range(0, 1)));
	endtask

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_TICK;
		data_byte = '0;
		send_start = 1'b0;
		send_stop = 1'b0;
		send_ack = 1'b0;
		sda_in = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		calm = 1'b0;
		board = new();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, at the reset phase length of one tick. A tick and
		// the spare code while idle must change nothing.
		send_request(make_request(ACT_TICK, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1));
		send_request(make_request(ACT_SPARE, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1));

		// Full write with start and stop, acknowledged. A read command and the
		// spare code arriving mid-byte must both be ignored.
		send_request(make_request(ACT_WRITE, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0));
		send_request(make_request(ACT_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
		send_request(make_request(ACT_READ, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0));
		send_request(make_request(ACT_SPARE, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
		tick_until_idle(1'b0);

		// Write without a start straight after a stop, so the first bit sees
		// the clock still high; the slave does not acknowledge. The ack flag
		// has no meaning for a write.
		send_request(make_request(ACT_WRITE, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1));
		tick_until_idle(1'b1);

		// Reads: all ones with ack, then all zeros with nack and a stop. The
		// data byte of a read command is ignored.
		send_request(make_request(ACT_READ, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b1));
		tick_until_idle(1'b1);
		send_request(make_request(ACT_READ, 8'hFF, 1'b0, 1'b1, 1'b0, 1'b0));
		tick_until_idle(1'b0);

		send_request(make_request(ACT_WRITE, 8'hA5, 1'b1, 1'b1, 1'b0, 1'b0));
		tick_until_idle(1'b0);
		send_request(make_request(ACT_WRITE, 8'h5A, 1'b0, 1'b1, 1'b1, 1'b1));
		tick_until_idle(1'b1);

		// A phase length of zero behaves as one tick.
		write_phase_len(10'd0);
		drive_random(150);
		write_phase_len(10'd2);
		drive_random(200);

		// The longest phase length: a byte is started and held in its first
		// phase for a few dozen ticks. A shorter length is then written with
		// nothing in flight, so the next tick ends that phase at once.
		write_phase_len(10'd1023);
		send_request(make_request($urandom_range(0, 1) ? ACT_WRITE : ACT_READ,
			ByteW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
		repeat (40) begin
			send_request(make_request(ACT_TICK, ByteW'($urandom_range(0, 255)), 1'b0, 1'b0,
				1'b0, 1'($urandom_range(0, 1))));
		end

		write_phase_len(10'd3);
		tick_until_idle(1'($urandom_range(0, 1)));
		drive_random(150);
		write_phase_len(10'd1);
		drive_random(150);
		write_phase_len(TickW'($urandom_range(4, 12)));
		drive_random(150);

		settle();
		repeat (8) @(negedge clk);
		if (board.fail_count == 0 && board.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
